>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/avcflv_pkg.sv
// shared types and constants of the flv video to annex b converter
// no dependencies
package avcflv_pkg;

    // decoder configuration packet marker and field layout
    localparam logic [7:0] CFG_MARK    = 8'h17;
    localparam int         COUNT_W     = 5;
    localparam logic [3:0] COUNT_INDEX = 4'd10;
    localparam logic [3:0] NAL_HDR_END = 4'd4;   // last header byte position before lengths
    localparam logic [3:0] NAL_LEN_BYTES = 4'd4;

    // start code 00 00 00 01 is sent as four beats
    localparam int         BEAT_W      = 2;
    localparam logic [BEAT_W-1:0] SC_LAST_BEAT = 2'd3;
    localparam logic [7:0] SC_FINAL_BYTE = 8'h01;

    // one result descriptor: either a start code burst or a single data byte
    typedef struct packed {
        logic       sync_burst;
        logic [7:0] data;
    } t_result;

endpackage

>>> rtl/avc_flv_to_annexb_converter.sv
// FLV video packet body bytes in, H.264 Annex B byte stream out. A byte is
// taken into an input register, parsed in one pass against the packet state
// (decoder configuration with SPS/PPS sets, or 5-byte header plus 32-bit
// length-prefixed NAL units), and its result goes to a result register.
// Ordinary bytes flow at one per cycle while the receiver takes them; a byte
// that ends a length field emits the start code 00 00 00 01 as four output
// transactions, held in the result register by the start code serializer.
// Bytes pass the input register, then the result register. run_last marks the
// final output byte caused by each input byte. No clearing pass after reset.
// depends on avcflv_pkg, avcflv_parser, avcflv_emitter
module avc_flv_to_annexb_converter
    import avcflv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_packet_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic    res_valid;
    logic    res_ready;
    t_result res;

    // input register and parser
    avcflv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_body_byte    (i_body_byte),
        .i_packet_start (i_packet_start),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // result register and start code serializer
    avcflv_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

>>> rtl/avcflv_parser.sv
// input register and packet parser: turns each body byte into a result descriptor
// depends on avcflv_pkg
module avcflv_parser
    import avcflv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic [7:0] i_body_byte,
    input  logic    i_packet_start,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    // parse phase codes
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_FIRST     = 4'd1;
    localparam logic [3:0] PH_CFG_HDR   = 4'd2;
    localparam logic [3:0] PH_SPS_HI    = 4'd3;
    localparam logic [3:0] PH_SPS_LO    = 4'd4;
    localparam logic [3:0] PH_SPS_DATA  = 4'd5;
    localparam logic [3:0] PH_PPS_COUNT = 4'd6;
    localparam logic [3:0] PH_PPS_HI    = 4'd7;
    localparam logic [3:0] PH_PPS_LO    = 4'd8;
    localparam logic [3:0] PH_PPS_DATA  = 4'd9;
    localparam logic [3:0] PH_NAL_HDR   = 4'd10;
    localparam logic [3:0] PH_NAL_LEN   = 4'd11;
    localparam logic [3:0] PH_NAL_DATA  = 4'd12;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // parser state
    logic [3:0]         r_phase, n_phase;
    logic               r_seen, n_seen;
    logic [3:0]         r_pos, n_pos;
    logic [7:0]         r_first, n_first;
    logic [23:0]        r_len, n_len;
    logic [31:0]        r_rem, n_rem;
    logic [COUNT_W-1:0] r_sets, n_sets;

    logic        gen;
    t_result     res;
    logic        advance;
    logic [31:0] full_len;
    logic [15:0] set_len;
    logic [3:0]  pos_inc;
    logic [COUNT_W-1:0] sets_dec;

    assign full_len = {r_len, r_in_byte};
    assign set_len  = {r_len[7:0], r_in_byte};
    assign pos_inc  = r_pos + 4'd1;
    assign sets_dec = r_sets - COUNT_W'(1);

    // next state and result for the held byte
    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_pos   = r_pos;
        n_first = r_first;
        n_len   = r_len;
        n_rem   = r_rem;
        n_sets  = r_sets;
        gen     = 1'b0;
        res.sync_burst = 1'b0;
        res.data       = r_in_byte;
        if (r_in_start) begin
            n_first = r_in_byte;
            n_pos   = 4'd1;
            n_phase = PH_FIRST;
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    n_pos = 4'd2;
                    if (r_first == CFG_MARK && r_in_byte == 8'd0) begin
                        n_seen  = 1'b1;
                        n_phase = PH_CFG_HDR;
                    end else if (r_seen) begin
                        n_phase = PH_NAL_HDR;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CFG_HDR: begin
                    if (r_pos == COUNT_INDEX) begin
                        n_sets  = r_in_byte[COUNT_W-1:0];
                        n_phase = (r_in_byte[COUNT_W-1:0] != '0) ? PH_SPS_HI : PH_PPS_COUNT;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_SPS_HI, PH_PPS_HI: begin
                    n_len   = {16'd0, r_in_byte};
                    n_phase = r_phase + 4'd1;
                end
                PH_SPS_LO, PH_PPS_LO: begin
                    n_rem          = {16'd0, set_len};
                    gen            = 1'b1;
                    res.sync_burst = 1'b1;
                    if (set_len != 16'd0) begin
                        n_phase = r_phase + 4'd1;
                    end else begin
                        n_sets = sets_dec;
                        if (r_phase == PH_SPS_LO) begin
                            n_phase = (sets_dec != '0) ? PH_SPS_HI : PH_PPS_COUNT;
                        end else begin
                            n_phase = (sets_dec != '0) ? PH_PPS_HI : PH_IDLE;
                        end
                    end
                end
                PH_SPS_DATA, PH_PPS_DATA: begin
                    gen   = 1'b1;
                    n_rem = r_rem - 32'd1;
                    if (r_rem == 32'd1) begin
                        n_sets = sets_dec;
                        if (r_phase == PH_SPS_DATA) begin
                            n_phase = (sets_dec != '0) ? PH_SPS_HI : PH_PPS_COUNT;
                        end else begin
                            n_phase = (sets_dec != '0) ? PH_PPS_HI : PH_IDLE;
                        end
                    end
                end
                PH_PPS_COUNT: begin
                    n_sets  = r_in_byte[COUNT_W-1:0];
                    n_phase = (r_in_byte[COUNT_W-1:0] != '0) ? PH_PPS_HI : PH_IDLE;
                end
                PH_NAL_HDR: begin
                    if (r_pos >= NAL_HDR_END) begin
                        n_phase = PH_NAL_LEN;
                        n_pos   = 4'd0;
                        n_len   = 24'd0;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
                PH_NAL_LEN: begin
                    if (pos_inc >= NAL_LEN_BYTES) begin
                        n_rem          = full_len;
                        gen            = 1'b1;
                        res.sync_burst = 1'b1;
                        n_pos          = 4'd0;
                        n_len          = 24'd0;
                        n_phase        = (full_len != 32'd0) ? PH_NAL_DATA : PH_NAL_LEN;
                    end else begin
                        n_pos = pos_inc;
                        n_len = full_len[23:0];
                    end
                end
                PH_NAL_DATA: begin
                    gen   = 1'b1;
                    n_rem = r_rem - 32'd1;
                    if (r_rem == 32'd1) begin
                        n_phase = PH_NAL_LEN;
                        n_pos   = 4'd0;
                        n_len   = 24'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // held byte moves on when it makes no result or the result register takes it
    assign advance     = r_in_valid && (!gen || i_res_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_res_valid = r_in_valid && gen;
    assign o_res       = res;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_body_byte;
            r_in_start <= i_packet_start;
        end
    end

    // parser state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seen  <= 1'b0;
            r_pos   <= 4'd0;
            r_first <= 8'd0;
            r_len   <= 24'd0;
            r_rem   <= 32'd0;
            r_sets  <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_seen  <= n_seen;
            r_pos   <= n_pos;
            r_first <= n_first;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_sets  <= n_sets;
        end
    end

endmodule

>>> rtl/avcflv_emitter.sv
// result register and start code serializer
// depends on avcflv_pkg
module avcflv_emitter
    import avcflv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_res_valid,
    output logic       o_res_ready,
    input  t_result    i_res,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic              r_valid;
    t_result           r_res;
    logic [BEAT_W-1:0] r_beat;
    logic              beat_last;
    logic              fire;
    logic              done;

    // a start code runs four beats, a data byte one
    assign beat_last   = !r_res.sync_burst || (r_beat == SC_LAST_BEAT);
    assign fire        = r_valid && i_ready;
    assign done        = fire && beat_last;
    assign o_res_ready = !r_valid || done;

    // output byte selection
    assign o_valid    = r_valid;
    assign o_run_last = beat_last;
    assign o_out_byte = r_res.sync_burst ? ((r_beat == SC_LAST_BEAT) ? SC_FINAL_BYTE : 8'd0)
                                         : r_res.data;

    // result register and beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
            r_beat  <= '0;
        end else if (fire) begin
            r_beat <= r_beat + BEAT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/avcflv_checker.sv
// port-level checks of the converter, attached by bind
// depends on assert_macros.svh and avc_flv_to_annexb_converter
`include "assert_macros.svh"

module avcflv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_body_byte,
    input logic       i_packet_start,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    logic [9:0] in_bus;
    logic [9:0] out_bus;

    // valid and payload of each channel, compared as one word
    assign in_bus  = {i_valid, i_body_byte, i_packet_start};
    assign out_bus = {o_valid, o_out_byte, o_run_last};

    // a stalled input transaction holds its payload
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, $stable(in_bus))

    // a stalled output transaction holds its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(out_bus))

    // only start code beats are non-final, and those carry zero
    `ASSERT_IMPL(a_sc_zero, i_clk, i_rst_n, o_valid && !o_run_last, o_out_byte == 8'd0)

    // a start code burst continues without a gap
    `ASSERT_NEXT(a_sc_burst, i_clk, i_rst_n, o_valid && i_ready && !o_run_last, o_valid)

    // with nothing waiting at the output the input is always taken
    `ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !o_valid, o_ready)

endmodule

bind avc_flv_to_annexb_converter avcflv_checker u_avcflv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_body_byte    (i_body_byte),
    .i_packet_start (i_packet_start),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_byte     (o_out_byte),
    .o_run_last     (o_run_last)
);

>>> tb/sv/annexb_stream_pkg.sv
`timescale 1ns / 1ps
// expected-stream tracker for the flv video to annex b converter testbench
// depends on avcflv_pkg for the marker, count index, header, length and start code constants
package annexb_stream_pkg;
    import avcflv_pkg::*;

    // parser phases of the converter
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_CFG_HDR,
        ST_SPS_HI,
        ST_SPS_LO,
        ST_SPS_DATA,
        ST_PPS_COUNT,
        ST_PPS_HI,
        ST_PPS_LO,
        ST_PPS_DATA,
        ST_NAL_HDR,
        ST_NAL_LEN,
        ST_NAL_DATA
    } t_parse_phase;

    // one output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_annexb_byte;

    localparam int REPORT_MAX = 10;

    class annexb_stream_tracker;
        t_parse_phase phase;
        logic         cfg_seen;
        logic [3:0]   pos;
        logic [7:0]   first_byte;
        logic [31:0]  len_acc;
        logic [31:0]  remaining;
        logic [4:0]   sets_left;
        t_annexb_byte due_bytes[$];
        int           mismatches;

        function new();
            phase      = ST_IDLE;
            cfg_seen   = 1'b0;
            pos        = '0;
            first_byte = '0;
            len_acc    = '0;
            remaining  = '0;
            sets_left  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void push_out(input logic [7:0] b);
            t_annexb_byte r;
            r.out_byte = b;
            r.run_last = 1'b0;
            due_bytes.push_back(r);
        endfunction

        function void push_sync_word();
            push_out(8'h00);
            push_out(8'h00);
            push_out(8'h00);
            push_out(SC_FINAL_BYTE);
        endfunction

        // one sps or pps entry done, move to the next entry or the next list
        function void close_set(input logic is_sps);
            sets_left = sets_left - 5'd1;
            if (sets_left != 0)
                phase = is_sps ? ST_SPS_HI : ST_PPS_HI;
            else
                phase = is_sps ? ST_PPS_COUNT : ST_IDLE;
        endfunction

        // advance the parser by one accepted body byte, queue the bytes it emits
        function void take_body_byte(input logic [7:0] b, input logic pkt_start);
            int base;
            base = due_bytes.size();
            if (pkt_start) begin
                first_byte = b;
                pos        = 4'd1;
                phase      = ST_FIRST;
                return;
            end
            case (phase)
                ST_FIRST: begin
                    pos = 4'd2;
                    if (first_byte == CFG_MARK && b == 8'h00) begin
                        cfg_seen = 1'b1;
                        phase    = ST_CFG_HDR;
                    end else if (cfg_seen) begin
                        phase = ST_NAL_HDR;
                    end else begin
                        phase = ST_IDLE;
                    end
                end
                ST_CFG_HDR: begin
                    if (pos == COUNT_INDEX) begin
                        sets_left = b[4:0];
                        phase     = (sets_left != 0) ? ST_SPS_HI : ST_PPS_COUNT;
                    end else begin
                        pos = pos + 4'd1;
                    end
                end
                ST_SPS_HI, ST_PPS_HI: begin
                    len_acc = {24'd0, b};
                    phase   = (phase == ST_SPS_HI) ? ST_SPS_LO : ST_PPS_LO;
                end
                ST_SPS_LO, ST_PPS_LO: begin
                    remaining = {16'd0, len_acc[7:0], b};
                    push_sync_word();
                    if (remaining != 0)
                        phase = (phase == ST_SPS_LO) ? ST_SPS_DATA : ST_PPS_DATA;
                    else
                        close_set(phase == ST_SPS_LO);
                end
                ST_SPS_DATA, ST_PPS_DATA: begin
                    push_out(b);
                    remaining = remaining - 32'd1;
                    if (remaining == 0)
                        close_set(phase == ST_SPS_DATA);
                end
                ST_PPS_COUNT: begin
                    sets_left = b[4:0];
                    phase     = (sets_left != 0) ? ST_PPS_HI : ST_IDLE;
                end
                ST_NAL_HDR: begin
                    if (pos >= NAL_HDR_END) begin
                        phase   = ST_NAL_LEN;
                        pos     = '0;
                        len_acc = '0;
                    end else begin
                        pos = pos + 4'd1;
                    end
                end
                ST_NAL_LEN: begin
                    len_acc = {len_acc[23:0], b};
                    pos     = pos + 4'd1;
                    if (pos >= NAL_LEN_BYTES) begin
                        remaining = len_acc;
                        push_sync_word();
                        pos     = '0;
                        len_acc = '0;
                        phase   = (remaining != 0) ? ST_NAL_DATA : ST_NAL_LEN;
                    end
                end
                ST_NAL_DATA: begin
                    push_out(b);
                    remaining = remaining - 32'd1;
                    if (remaining == 0) begin
                        phase   = ST_NAL_LEN;
                        pos     = '0;
                        len_acc = '0;
                    end
                end
                default: phase = ST_IDLE;
            endcase
            // flag the final byte of this run
            if (due_bytes.size() > base)
                due_bytes[due_bytes.size() - 1].run_last = 1'b1;
        endfunction

        // compare one output transaction against the oldest due byte
        function void match_out_byte(input logic [7:0] b, input logic last);
            t_annexb_byte want;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output byte %h run_last %b", b, last);
                return;
            end
            want = due_bytes.pop_front();
            if (want.out_byte !== b || want.run_last !== last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("output mismatch: want byte %h run_last %b, got byte %h run_last %b",
                             want.out_byte, want.run_last, b, last);
            end
        endfunction
    endclass

endpackage

>>> tb/sv/avc_flv_to_annexb_converter_tb.sv
`timescale 1ns / 1ps
// testbench top for avc_flv_to_annexb_converter: directed and random flv packets
// depends on avcflv_pkg, annexb_stream_pkg and the converter rtl
module avc_flv_to_annexb_converter_tb;
    import avcflv_pkg::*;
    import annexb_stream_pkg::*;

    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_body_byte    = 8'h00;
    logic       i_packet_start = 1'b0;
    logic       i_ready        = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    annexb_stream_tracker tracker;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         quiet_cycles  = 0;
    int         item_count    = 0;
    logic [7:0] pkt_q[$];
    bit         pkt_cut;

    always #2 i_clk = ~i_clk;

    avc_flv_to_annexb_converter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_body_byte    (i_body_byte),
        .i_packet_start (i_packet_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.take_body_byte(i_body_byte, i_packet_start);
            if (o_valid && i_ready)
                tracker.match_out_byte(o_out_byte, o_run_last);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no transaction
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic pkt_start);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_body_byte    <= b;
        i_packet_start <= pkt_start;
        do @(posedge i_clk); while (!o_ready);
        item_count++;
    endtask

    // sender holds off until every due byte has come out
    task automatic drain_output();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_packet();
        foreach (pkt_q[k])
            send_item(pkt_q[k], k == 0);
    endtask

    // one sps or pps entry; a long length is cut short by the packet end
    task automatic add_param_set();
        int len;
        if ($urandom_range(7) == 0) begin
            pkt_q.push_back(8'($urandom_range(1, 255)));
            pkt_q.push_back(8'($urandom));
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
            pkt_cut = 1'b1;
        end else begin
            len = $urandom_range(3);
            pkt_q.push_back(8'h00);
            pkt_q.push_back(8'(len));
            repeat (len) pkt_q.push_back(8'($urandom));
        end
    endtask

    task automatic build_config_packet();
        int n_sets;
        pkt_q   = {};
        pkt_cut = 1'b0;
        pkt_q.push_back(CFG_MARK);
        pkt_q.push_back(8'h00);
        repeat (8) pkt_q.push_back(8'($urandom));
        n_sets = $urandom_range(2);
        pkt_q.push_back({3'($urandom), 5'(n_sets)});
        repeat (n_sets) if (!pkt_cut) add_param_set();
        if (pkt_cut) return;
        n_sets = $urandom_range(2);
        pkt_q.push_back({3'($urandom), 5'(n_sets)});
        repeat (n_sets) if (!pkt_cut) add_param_set();
        // trailing bytes after the last pps
        if (!pkt_cut && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
    endtask

    task automatic build_nal_packet();
        logic [31:0] len;
        pkt_q = {};
        pkt_q.push_back(8'($urandom));
        // keep it from looking like a configuration
        if (pkt_q[0] == CFG_MARK)
            pkt_q.push_back(8'($urandom_range(1, 255)));
        else
            pkt_q.push_back(8'($urandom));
        repeat (3) pkt_q.push_back(8'($urandom));
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(9) == 0) begin
                len = {8'($urandom_range(1, 255)), 24'($urandom)};
                for (int k = 3; k >= 0; k--) pkt_q.push_back(len[8*k +: 8]);
                repeat ($urandom_range(1, 3)) pkt_q.push_back(8'($urandom));
                return;
            end
            len = $urandom_range(4);
            for (int k = 3; k >= 0; k--) pkt_q.push_back(len[8*k +: 8]);
            repeat (len) pkt_q.push_back(8'($urandom));
        end
    endtask

    initial begin
        int cur_mode;
        tracker  = new();
        cur_mode = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle byte, packet before any configuration
        send_item(8'h5a, 1'b0);
        send_item(8'h27, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b0);
        // configuration: one sps of one byte, one empty pps, trailing byte
        send_item(CFG_MARK, 1'b1);
        send_item(8'h00, 1'b0);
        for (int k = 0; k < 8; k++)
            send_item(k[0] ? 8'h00 : 8'hff, 1'b0);
        send_item(8'he1, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h21, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);

        // random packets over the idling phases, each phase visited in turn
        while (cur_mode < 3 || item_count < RANDOM_ITEMS) begin
            if (cur_mode < 3 && item_count * 4 >= (cur_mode + 1) * RANDOM_ITEMS) begin
                drain_output();
                cur_mode++;
                case (cur_mode)
                    1: begin send_idle_pct = 46; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 46; end
                    default: begin send_idle_pct = 14; stall_pct = 14; end
                endcase
            end
            case ($urandom_range(7))
                0, 1: build_config_packet();
                2, 3, 4, 5: build_nal_packet();
                default: begin
                    // noise with random packet starts
                    repeat ($urandom_range(1, 4))
                        send_item(8'($urandom), $urandom_range(3) == 0);
                    continue;
                end
            endcase
            // cut a packet short now and then
            if ($urandom_range(5) == 0)
                pkt_q = pkt_q[0:$urandom_range(pkt_q.size() - 1)];
            send_packet();
        end

        drain_output();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
